/* design/ucds_pkg.sv */
`timescale 1ns / 1ps

package ucds_pkg;

    // utf-8 lead byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;

    // payload masks for code point assembly
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    // sequence lengths
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // plain letter for a czech accented code point, zero when not listed
    function automatic logic [7:0] f_strip(input logic [15:0] cp);
        logic [7:0] letter;
        begin
            case (cp)
                16'h00E1: letter = "a";
                16'h010D: letter = "c";
                16'h0159: letter = "r";
                16'h00E9: letter = "e";
                16'h00ED: letter = "i";
                16'h011B: letter = "e";
                16'h0161: letter = "s";
                16'h0165: letter = "t";
                16'h017E: letter = "z";
                16'h010F: letter = "d";
                16'h00F3: letter = "o";
                16'h016F: letter = "u";
                16'h00FD: letter = "y";
                16'h00C1: letter = "A";
                16'h010C: letter = "C";
                16'h0158: letter = "R";
                16'h00C9: letter = "E";
                16'h00CD: letter = "I";
                16'h011A: letter = "E";
                16'h0160: letter = "S";
                16'h0164: letter = "T";
                16'h017D: letter = "Z";
                16'h010E: letter = "D";
                16'h0147: letter = "N";
                16'h00D3: letter = "O";
                16'h00DA: letter = "U";
                16'h016E: letter = "U";
                16'h00DD: letter = "Y";
                default:  letter = 8'h00;
            endcase
            return letter;
        end
    endfunction

endpackage

/* design/utf8_czech_diacritic_stripper_core.sv */
`timescale 1ns / 1ps
// path: an input byte is first taken into the input register and then decoded into the
// result register, from which its results transfer
// throughput: one input byte per cycle while each byte yields at most one result and the
// output is ready; a run of result bytes holds the result register until it drains
// reset: synchronous active-low i_rst_n empties both registers and closes any open sequence
module utf8_czech_diacritic_stripper_core
    import ucds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // last_of_run
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // open sequence state
    logic [7:0] r_held [2];
    logic [1:0] r_hc;
    logic [1:0] r_exp;
    logic [7:0] n_held [2];
    logic [1:0] n_hc;
    logic [1:0] n_exp;

    // result register
    logic       r_out_vld;
    logic [7:0] r_ob [3];
    logic [1:0] r_ocnt;
    logic [1:0] r_oidx;
    logic [7:0] n_ob [3];
    logic [1:0] n_ocnt;

    logic out_free;
    logic consume;
    logic out_xfer;

    // handshake
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_ob[r_oidx];
    assign m_axis_tlast  = (r_oidx == (r_ocnt - 2'd1));
    assign out_xfer      = r_out_vld && m_axis_tready;
    assign out_free      = !r_out_vld || (m_axis_tready && m_axis_tlast);
    assign consume       = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;

    // input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // decode one byte against the open sequence
    always_comb begin
        logic        open_seq;
        logic        is_lead2;
        logic        is_lead3;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [15:0] cp;
        logic [7:0]  letter;
        logic [7:0]  stray;
        open_seq = ((r_hc == 2'd1) || (r_hc == 2'd2)) &&
                   ((r_exp == LEN_TWO) || (r_exp == LEN_THREE));
        is_lead2 = (r_in_byte & LEAD2_MASK) == LEAD2_CODE;
        is_lead3 = (r_in_byte & LEAD3_MASK) == LEAD3_CODE;
        s0 = r_held[0];
        s1 = (r_hc == 2'd1) ? r_in_byte : r_held[1];
        s2 = r_in_byte;
        if (r_exp == LEN_TWO) begin
            cp = {5'd0, s0[4:0] & LEAD2_BITS[4:0], s1[5:0] & CONT_BITS[5:0]};
        end else begin
            cp = {s0[3:0] & LEAD3_BITS[3:0], s1[5:0] & CONT_BITS[5:0],
                  s2[5:0] & CONT_BITS[5:0]};
        end
        letter = f_strip(cp);
        stray  = f_strip({8'h00, r_in_byte});

        n_held = r_held;
        n_hc   = r_hc;
        n_exp  = r_exp;
        n_ob[0] = r_in_byte;
        n_ob[1] = s1;
        n_ob[2] = s2;
        n_ocnt  = 2'd0;

        if (!open_seq) begin
            n_hc  = 2'd0;
            n_exp = LEN_NONE;
            if (r_in_byte < ASCII_LIMIT) begin
                n_ocnt = 2'd1;
            end else if (is_lead2 || is_lead3) begin
                if (r_in_last) begin
                    n_ocnt = 2'd1;
                end else begin
                    n_held[0] = r_in_byte;
                    n_hc      = 2'd1;
                    n_exp     = is_lead2 ? LEN_TWO : LEN_THREE;
                end
            end else begin
                n_ocnt  = 2'd1;
                n_ob[0] = (stray != 8'h00) ? stray : r_in_byte;
            end
        end else if ((r_hc + 2'd1) == r_exp) begin
            // sequence complete
            n_hc  = 2'd0;
            n_exp = LEN_NONE;
            if (letter != 8'h00) begin
                n_ob[0] = letter;
                n_ocnt  = 2'd1;
            end else begin
                n_ob[0] = s0;
                n_ocnt  = r_exp;
            end
        end else if (r_in_last) begin
            // flush an incomplete sequence
            n_hc    = 2'd0;
            n_exp   = LEN_NONE;
            n_ob[0] = s0;
            n_ocnt  = r_hc + 2'd1;
        end else begin
            n_held[r_hc[0]] = r_in_byte;
            n_hc            = r_hc + 2'd1;
        end
    end

    // sequence state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc  <= 2'd0;
            r_exp <= LEN_NONE;
        end else if (consume) begin
            r_hc  <= n_hc;
            r_exp <= n_exp;
        end
        if (consume) begin
            r_held <= n_held;
        end
    end

    // result register, drained one byte per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_oidx    <= 2'd0;
            r_ocnt    <= 2'd0;
        end else if (consume && (n_ocnt != 2'd0)) begin
            r_out_vld <= 1'b1;
            r_oidx    <= 2'd0;
            r_ocnt    <= n_ocnt;
        end else if (out_xfer) begin
            if (m_axis_tlast) begin
                r_out_vld <= 1'b0;
            end else begin
                r_oidx <= r_oidx + 2'd1;
            end
        end
        if (consume && (n_ocnt != 2'd0)) begin
            r_ob <= n_ob;
        end
    end

`ifndef SYNTH
    // a valid result register always points inside its run
    a_run_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_ocnt != 2'd0) && (r_oidx < r_ocnt)))
        else $error("result index outside run");

    // an open sequence never holds as many bytes as it needs
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hc != 2'd0) |-> ((r_hc < r_exp) && (r_exp != LEN_NONE)))
        else $error("held count not below expected length");

    // a run continues after a transfer that is not its last
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("run cut short");

    // a stalled input byte stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !consume) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("input byte lost while stalled");
`endif

endmodule
